>>> sv/gsd_pkg.sv
`default_nettype none
package gsd_pkg;

   localparam int unsigned GSD_LFSR_W    = 31;
   localparam int unsigned GSD_SOFT_W    = 16;
   localparam int unsigned GSD_SKIP_W    = 16;
   localparam int unsigned GSD_CNT_W     = 17;
   localparam int unsigned GSD_DATA_W    = 32;
   localparam int unsigned GSD_ADDR_W    = 3;
   localparam int unsigned GSD_QDEPTH    = 4;
   localparam int unsigned GSD_QPTR_W    = $clog2(GSD_QDEPTH);
   localparam int unsigned GSD_QCNT_W    = $clog2(GSD_QDEPTH + 1);
   localparam int unsigned WARMUP_STEPS  = 1600;

   localparam logic [GSD_LFSR_W-1:0] GSD_X1_INIT  = 31'h4000_0000;
   localparam logic [GSD_CNT_W-1:0]  GSD_WARMUP   = GSD_CNT_W'(WARMUP_STEPS);
   localparam logic [GSD_SOFT_W-1:0] GSD_SOFT_MIN = 16'h8000;
   localparam logic [GSD_SOFT_W-1:0] GSD_SOFT_MAX = 16'h7FFF;

   localparam logic GSD_REG_C_INIT   = 1'b0;
   localparam logic GSD_REG_SKIP_LEN = 1'b1;

   typedef struct packed {
      logic [GSD_SOFT_W-1:0] soft_val;
      logic                  start;
   } gsd_item_type;

   typedef enum logic [1:0] {
      GSD_RUN,
      GSD_WARM,
      GSD_FIRST
   } gsd_state_type;

   function automatic logic [GSD_LFSR_W-1:0] gsd_x1_next(input logic [GSD_LFSR_W-1:0] r);
      gsd_x1_next = {r[GSD_LFSR_W-2:0], r[30] ^ r[27]};
   endfunction

   function automatic logic [GSD_LFSR_W-1:0] gsd_x2_next(input logic [GSD_LFSR_W-1:0] r);
      gsd_x2_next = {r[GSD_LFSR_W-2:0], r[30] ^ r[29] ^ r[28] ^ r[27]};
   endfunction

   function automatic logic [GSD_LFSR_W-1:0] gsd_reverse(input logic [GSD_LFSR_W-1:0] v);
      logic [GSD_LFSR_W-1:0] r;
      for (int i = 0; i < GSD_LFSR_W; i++) begin
         r[i] = v[GSD_LFSR_W-1-i];
      end
      gsd_reverse = r;
   endfunction

   function automatic logic [GSD_SOFT_W-1:0] gsd_negate(input logic [GSD_SOFT_W-1:0] v);
      if (v == GSD_SOFT_MIN) begin
         gsd_negate = GSD_SOFT_MAX;
      end else begin
         gsd_negate = (~v) + 1'b1;
      end
   endfunction

endpackage
`default_nettype wire

>>> sv/gsd_queue.sv
`default_nettype none
module gsd_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic signed [15:0]    req_soft_in,
   input  wire logic                  req_start_req,
   output logic                       head_valid,
   output gsd_pkg::gsd_item_type      head_item,
   input  wire logic                  pop
);
   import gsd_pkg::*;

   gsd_item_type          mem_ff [GSD_QDEPTH];
   logic [GSD_QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [GSD_QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [GSD_QCNT_W-1:0] count_ff, count_in;
   logic                  push;

   assign req_stall  = (count_ff == GSD_QCNT_W'(GSD_QDEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{soft_val: req_soft_in, start: req_start_req};
      end
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= GSD_QCNT_W'(GSD_QDEPTH))
      else $error("queue count beyond depth");
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == GSD_QCNT_W'(GSD_QDEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif
endmodule
`default_nettype wire

>>> sv/gsd_back.sv
`default_nettype none
module gsd_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [30:0]           c_init,
   input  wire logic [15:0]           skip_len,
   input  wire logic                  head_valid,
   input  wire gsd_pkg::gsd_item_type head_item,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [15:0]         rsp_soft_out
);
   import gsd_pkg::*;

   gsd_state_type         state_ff, state_in;
   logic [GSD_LFSR_W-1:0] x1_ff, x1_in;
   logic [GSD_LFSR_W-1:0] x2_ff, x2_in;
   logic [GSD_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  out_valid_ff, out_valid_in;
   logic [GSD_SOFT_W-1:0] out_soft_ff, out_soft_in;
   logic                  out_free;
   logic                  seq_bit;

   assign out_free     = !out_valid_ff || !rsp_stall;
   assign seq_bit      = x1_ff[GSD_LFSR_W-1] ^ x2_ff[GSD_LFSR_W-1];
   assign rsp_valid    = out_valid_ff;
   assign rsp_soft_out = out_soft_ff;

   always_comb begin
      state_in     = state_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      cnt_in       = cnt_ff;
      out_soft_in  = out_soft_ff;
      out_valid_in = out_free ? 1'b0 : out_valid_ff;
      pop          = 1'b0;
      case (state_ff)
         GSD_RUN: begin
            if (head_valid && out_free) begin
               if (head_item.start) begin
                  // reload, then spend the warm-up on the same request
                  x1_in    = GSD_X1_INIT;
                  x2_in    = gsd_reverse(c_init);
                  cnt_in   = GSD_WARMUP + GSD_CNT_W'(skip_len);
                  state_in = GSD_WARM;
               end else begin
                  pop = 1'b1;
               end
            end
         end
         GSD_WARM: begin
            x1_in  = gsd_x1_next(x1_ff);
            x2_in  = gsd_x2_next(x2_ff);
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == GSD_CNT_W'(1)) begin
               state_in = GSD_FIRST;
            end
         end
         GSD_FIRST: begin
            if (head_valid && out_free) begin
               pop      = 1'b1;
               state_in = GSD_RUN;
            end
         end
         default: begin
            state_in = GSD_RUN;
         end
      endcase
      if (pop) begin
         x1_in        = gsd_x1_next(x1_ff);
         x2_in        = gsd_x2_next(x2_ff);
         out_valid_in = 1'b1;
         out_soft_in  = seq_bit ? gsd_negate(head_item.soft_val) : head_item.soft_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= GSD_RUN;
         x1_ff        <= GSD_X1_INIT;
         x2_ff        <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x1_ff        <= x1_in;
         x2_ff        <= x2_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_soft_ff <= out_soft_in;
   end

`ifndef SYNTH
   a_warm_no_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == GSD_WARM) |-> !pop)
      else $error("request taken during warm-up");
   a_warm_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == GSD_WARM) |-> (cnt_ff != '0))
      else $error("warm-up count at zero while warming");
   a_pop_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> (head_valid && out_free))
      else $error("pop without request or output room");
   a_first_after_warm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == GSD_FIRST) |-> (cnt_ff == '0))
      else $error("first request processed before warm-up done");
`endif
endmodule
`default_nettype wire

>>> sv/gold_sequence_descrambler.sv
`default_nettype none
// Soft-bit descrambler for the length-31 Gold sequence (x1 and x2 LFSRs). Requests enter a
// four-entry queue and a back end steps both LFSRs once per request, so the steady rate is one
// request per cycle while the receiver does not stall and no warm-up runs. A request passes
// through the queue register and the output register on its way to the response. A request
// with start_req set reloads x1 with its fixed seed and x2 with c_init bit-reversed, then
// steps both LFSRs 1600 + skip_len times before it is processed. c_init and skip_len are
// registers at byte addresses 0 and 4; writes take effect at the next start request.
module gold_sequence_descrambler (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic signed [15:0]  req_soft_in,
   input  wire logic                req_start_req,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [15:0]       rsp_soft_out,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import gsd_pkg::*;

   logic [GSD_LFSR_W-1:0] c_init_ff;
   logic [GSD_SKIP_W-1:0] skip_len_ff;
   logic                  csr_write;
   logic                  head_valid;
   gsd_item_type          head_item;
   logic                  pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_init_ff   <= '0;
         skip_len_ff <= '0;
      end else if (csr_write) begin
         case (paddr[2])
            GSD_REG_C_INIT:   c_init_ff   <= pwdata[GSD_LFSR_W-1:0];
            GSD_REG_SKIP_LEN: skip_len_ff <= pwdata[GSD_SKIP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         GSD_REG_C_INIT:   prdata = GSD_DATA_W'(c_init_ff);
         GSD_REG_SKIP_LEN: prdata = GSD_DATA_W'(skip_len_ff);
         default:          prdata = '0;
      endcase
   end

   gsd_queue u_queue (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_soft_in   (req_soft_in),
      .req_start_req (req_start_req),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop)
   );

   gsd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .c_init       (c_init_ff),
      .skip_len     (skip_len_ff),
      .head_valid   (head_valid),
      .head_item    (head_item),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_soft_out (rsp_soft_out)
   );

endmodule
`default_nettype wire

>>> tb/tb_gold_sequence_descrambler.sv
`timescale 1ns / 1ps
module tb_gold_sequence_descrambler;
   import gsd_pkg::*;

   localparam int WATCHDOG_LIMIT = 250000;
   localparam int N_PHASES       = 18;
   localparam int N_DIR          = 18;
   localparam int HOLD_CYCLES    = 80;
   localparam int REPORT_MAX     = 10;
   localparam int BIG_SKIP_PHASE = 16;
   localparam int HOLD_PHASE     = 13;
   localparam int DRAIN_PHASE    = 14;

   typedef logic signed [GSD_SOFT_W-1:0] soft_type;

   typedef struct packed {
      soft_type soft_val;
      logic     start;
      logic     fixed;
      soft_type soft_exp;
   } dir_row_type;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   soft_type              req_soft_in   = '0;
   logic                  req_start_req = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   soft_type              rsp_soft_out;
   logic                  psel          = 1'b0;
   logic                  penable       = 1'b0;
   logic                  pwrite        = 1'b0;
   logic [GSD_ADDR_W-1:0] paddr         = '0;
   logic [GSD_DATA_W-1:0] pwdata        = '0;
   logic [GSD_DATA_W-1:0] prdata;
   logic                  pready;

   // sequence generator state and register copies
   logic [GSD_LFSR_W-1:0] x1_seq;
   logic [GSD_LFSR_W-1:0] x2_seq;
   logic [GSD_LFSR_W-1:0] c_init_cfg;
   logic [GSD_SKIP_W-1:0] skip_cfg;

   soft_type soft_exp_q[$];
   int    errors         = 0;
   int    send_idle_pct  = 10;
   int    recv_stall_pct = 62;
   int    hold_asks      = 0;
   int    hold_done      = 0;
   int    hold_left      = 0;
   int    quiet_cycles   = 0;

   dir_row_type dir_rows [N_DIR] = '{
      '{16'h8000, 1'b0, 1'b1, 16'h7FFF},
      '{16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
      '{16'h8000, 1'b0, 1'b1, 16'h8000},
      '{16'h0000, 1'b0, 1'b1, 16'h0000},
      '{16'hFFFF, 1'b0, 1'b1, 16'hFFFF},
      '{16'h0001, 1'b0, 1'b1, 16'h0001},
      '{16'h5555, 1'b0, 1'b1, 16'h5555},
      '{16'hAAAA, 1'b0, 1'b1, 16'hAAAA},
      '{16'h04D2, 1'b1, 1'b0, 16'h0000},
      '{16'h8000, 1'b0, 1'b0, 16'h0000},
      '{16'h7FFF, 1'b0, 1'b0, 16'h0000},
      '{16'hFFFF, 1'b0, 1'b0, 16'h0000},
      '{16'h0001, 1'b0, 1'b0, 16'h0000},
      '{16'h8000, 1'b1, 1'b0, 16'h0000},
      '{16'h8000, 1'b1, 1'b0, 16'h0000},
      '{16'h7FFF, 1'b0, 1'b0, 16'h0000},
      '{16'h0000, 1'b0, 1'b0, 16'h0000},
      '{16'h1234, 1'b0, 1'b0, 16'h0000}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   gold_sequence_descrambler u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_soft_in   (req_soft_in),
      .req_start_req (req_start_req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_soft_out  (rsp_soft_out),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   function automatic void gold_advance(input int unsigned n);
      logic fb1;
      logic fb2;
      repeat (n) begin
         fb1    = x1_seq[30] ^ x1_seq[27];
         fb2    = x2_seq[30] ^ x2_seq[29] ^ x2_seq[28] ^ x2_seq[27];
         x1_seq = {x1_seq[GSD_LFSR_W-2:0], fb1};
         x2_seq = {x2_seq[GSD_LFSR_W-2:0], fb2};
      end
   endfunction

   function automatic soft_type descramble(input soft_type s, input logic st);
      logic flip;
      if (st) begin
         x1_seq = GSD_X1_INIT;
         for (int i = 0; i < GSD_LFSR_W; i++) begin
            x2_seq[GSD_LFSR_W-1-i] = c_init_cfg[i];
         end
         gold_advance(WARMUP_STEPS + skip_cfg);
      end
      flip = x1_seq[30] ^ x2_seq[30];
      gold_advance(1);
      if (!flip) begin
         return s;
      end
      return (s == soft_type'(GSD_SOFT_MIN)) ? soft_type'(GSD_SOFT_MAX) : -s;
   endfunction

   function automatic void flag_mismatch(input string what, input longint want,
                                         input longint got);
      errors++;
      if (errors <= REPORT_MAX) begin
         $display("mismatch %s: expected %0d, got %0d", what, want, got);
      end
   endfunction

   task automatic send_soft(input soft_type s, input logic st, input logic use_fixed,
                            input soft_type fixed_exp);
      soft_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_soft_in   <= s;
      req_start_req <= st;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predicted = descramble(s, st);
      soft_exp_q.push_back(use_fixed ? fixed_exp : predicted);
   endtask

   task automatic csr_write(input logic reg_idx, input logic [GSD_DATA_W-1:0] value);
      logic [GSD_DATA_W-1:0] readback;
      logic [GSD_DATA_W-1:0] want;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      // read back the same register
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (reg_idx == GSD_REG_C_INIT) begin
         c_init_cfg = value[GSD_LFSR_W-1:0];
         want       = GSD_DATA_W'(c_init_cfg);
      end else begin
         skip_cfg = value[GSD_SKIP_W-1:0];
         want     = GSD_DATA_W'(skip_cfg);
      end
      if (readback !== want) begin
         flag_mismatch("register readback", want, readback);
      end
   endtask

   // response checker and receiver stall
   always @(posedge clock) begin
      soft_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (soft_exp_q.size() == 0) begin
            flag_mismatch("unexpected response", 0, rsp_soft_out);
         end else begin
            want = soft_exp_q.pop_front();
            if (rsp_soft_out !== want) begin
               flag_mismatch("soft_out", want, rsp_soft_out);
            end
         end
      end
      if (hold_left > 0) begin
         hold_left--;
      end else if (hold_asks != hold_done) begin
         hold_done++;
         hold_left = HOLD_CYCLES;
      end
      rsp_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_gold_sequence_descrambler: done, errors");
         $finish;
      end
   end

   initial begin
      int                    n_items;
      logic                  st;
      soft_type              s;
      logic [GSD_DATA_W-1:0] word;
      logic [GSD_SKIP_W-1:0] skip;
      x1_seq     = GSD_X1_INIT;
      x2_seq     = '0;
      c_init_cfg = '0;
      skip_cfg   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_soft(dir_rows[i].soft_val, dir_rows[i].start, dir_rows[i].fixed,
                   dir_rows[i].soft_exp);
      end
      req_valid <= 1'b0;

      for (int p = 0; p < N_PHASES; p++) begin
         wait (soft_exp_q.size() == 0);
         @(posedge clock);
         repeat (4) @(posedge clock);
         if (p < 6) begin
            send_idle_pct  = 10;
            recv_stall_pct = 62;
         end else if (p < 12) begin
            send_idle_pct  = 62;
            recv_stall_pct = 10;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end

         case (p)
            0:       word = 32'h0000_0000;
            1:       word = 32'hFFFF_FFFF;
            default: word = $urandom();
         endcase
         csr_write(GSD_REG_C_INIT, word);
         case (p)
            0, 1:           skip = '0;
            BIG_SKIP_PHASE: skip = '1;
            default:        skip = GSD_SKIP_W'($urandom_range(0, 200));
         endcase
         word = ($urandom() & 32'hFFFF_0000) | GSD_DATA_W'(skip);
         csr_write(GSD_REG_SKIP_LEN, word);

         n_items = $urandom_range(80, 110);
         for (int k = 0; k < n_items; k++) begin
            // every fourth phase keeps running the old block across the register change
            if (k == 0) begin
               st = (p % 4 != 3);
            end else begin
               st = (p != BIG_SKIP_PHASE) && ($urandom_range(39) == 0);
            end
            if ($urandom_range(15) == 0) begin
               case ($urandom_range(3))
                  0:       s = soft_type'(GSD_SOFT_MIN);
                  1:       s = soft_type'(GSD_SOFT_MAX);
                  2:       s = '0;
                  default: s = '1;
               endcase
            end else begin
               s = soft_type'($urandom());
            end
            if (p == HOLD_PHASE && k == 20) begin
               hold_asks++;
            end
            if (p == DRAIN_PHASE && k == 40) begin
               req_valid <= 1'b0;
               wait (soft_exp_q.size() == 0);
               @(posedge clock);
            end
            send_soft(s, st, 1'b0, '0);
         end
         req_valid <= 1'b0;
      end

      wait (soft_exp_q.size() == 0);
      repeat (20) @(posedge clock);
      if (soft_exp_q.size() != 0) begin
         flag_mismatch("responses left over", 0, soft_exp_q.size());
      end
      if (errors == 0) begin
         $display("tb_gold_sequence_descrambler: done, clean");
      end else begin
         $display("tb_gold_sequence_descrambler: done, errors");
      end
      $finish;
   end

endmodule
